FILE: rtl/mhpq_pkg.sv
package mhpq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_SET     = 2'd2,
    CMD_DELETE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DEL_HOLD,
    S_DEL_RD,
    S_DEL_WR,
    S_LAST_RD,
    S_LAST_WAIT,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

endpackage

FILE: rtl/max_heap_priority_queue_top.sv
// Binary max-heap of signed 32-bit keys, one command per input word and exactly one
// result word per command. The heap lives in a single memory with one write port and
// two registered read ports; keys move through a hole held in registers, so each level
// of a sift is a read step followed by a compare and write-back step. An insert or set
// climbs until it reaches the root or stops below a parent that is not smaller; an
// extract moves the last entry to the root and descends until it reaches a slot without
// children or stops earlier, and takes the only entry without a sift; a delete first
// moves its hole up to the root and then finishes as an extract; rejected commands go
// straight to the result. A stalled result keeps its command in the final state and
// holds off the next command.
// Inputs are taken only while no command is in flight, and the result sits in an output
// register while the next command starts. Slots are read only after they are written,
// so no clearing pass follows reset.
module max_heap_priority_queue_top #(
  parameter int CAPACITY = 64,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic signed [31:0]  key,
  input  logic [IDX_W-1:0]    position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic signed [31:0]  removed_value,
  output logic signed [31:0]  top_value,
  output logic                top_valid,
  output logic [CNT_W-1:0]    entry_count
);

  localparam int W = IDX_W + 2;

  mhpq_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] hole, hole_next;
  logic signed [31:0] moving, moving_next;
  logic signed [31:0] result_removed, result_removed_next;
  logic [1:0] result_status, result_status_next;
  logic signed [31:0] top_key;

  logic signed [31:0] heap_mem [CAPACITY];
  logic signed [31:0] rd_a, rd_b;
  logic [IDX_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic signed [31:0] wr_data;
  logic wr_en;
  logic out_load;

  logic [W-1:0] lc_w, rc_w, cnt_w;
  logic [IDX_W-1:0] parent;
  logic lc_gt, rc_gt, pos_bad;
  logic signed [31:0] best_val;

  assign lc_w = {1'b0, hole, 1'b1};
  assign rc_w = lc_w + W'(1);
  assign cnt_w = W'(cnt);
  assign parent = (hole - IDX_W'(1)) >> 1;
  assign pos_bad = CNT_W'(position) >= cnt;
  assign lc_gt = rd_a > moving;
  assign best_val = lc_gt ? rd_a : moving;
  assign rc_gt = (rc_w < cnt_w) && (rd_b > best_val);
  assign in_stall = state != mhpq_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a <= heap_mem[rd_addr_a];
    rd_b <= heap_mem[rd_addr_b];
    if (wr_en && wr_addr == '0) begin
      top_key <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    hole <= hole_next;
    moving <= moving_next;
    result_removed <= result_removed_next;
    result_status <= result_status_next;
    if (out_load) begin
      status <= result_status;
      removed_value <= result_removed;
      top_value <= (cnt != '0) ? top_key : 32'sd0;
      top_valid <= cnt != '0;
      entry_count <= cnt;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    hole_next = hole;
    moving_next = moving;
    result_removed_next = result_removed;
    result_status_next = result_status;
    wr_en = 1'b0;
    wr_addr = hole;
    wr_data = moving;
    rd_addr_a = position;
    rd_addr_b = rc_w[IDX_W-1:0];
    out_load = 1'b0;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (in_valid) begin
          result_removed_next = 32'sd0;
          result_status_next = mhpq_pkg::STAT_OK;
          state_next = mhpq_pkg::S_DONE;
          case (mhpq_pkg::cmd_t'(cmd))
            mhpq_pkg::CMD_INSERT: begin
              if (cnt == CNT_W'(CAPACITY)) begin
                result_status_next = mhpq_pkg::STAT_FULL;
              end else begin
                hole_next = cnt[IDX_W-1:0];
                moving_next = key;
                cnt_next = cnt + CNT_W'(1);
                state_next = mhpq_pkg::S_UP_RD;
              end
            end
            mhpq_pkg::CMD_EXTRACT: begin
              if (cnt == '0) begin
                result_status_next = mhpq_pkg::STAT_EMPTY;
                result_removed_next = mhpq_pkg::KEY_MIN;
              end else begin
                result_removed_next = top_key;
                cnt_next = cnt - CNT_W'(1);
                if (cnt != CNT_W'(1)) begin
                  state_next = mhpq_pkg::S_LAST_RD;
                end
              end
            end
            mhpq_pkg::CMD_SET: begin
              if (pos_bad) begin
                result_status_next = mhpq_pkg::STAT_BAD_INDEX;
              end else begin
                hole_next = position;
                moving_next = key;
                state_next = mhpq_pkg::S_UP_RD;
              end
            end
            default: begin
              if (pos_bad) begin
                result_status_next = mhpq_pkg::STAT_BAD_INDEX;
              end else begin
                hole_next = position;
                state_next = mhpq_pkg::S_DEL_HOLD;
              end
            end
          endcase
        end
      end
      mhpq_pkg::S_UP_RD: begin
        if (hole == '0) begin
          wr_en = 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          rd_addr_a = parent;
          state_next = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_a < moving) begin
          wr_data = rd_a;
          hole_next = parent;
          state_next = mhpq_pkg::S_UP_RD;
        end else begin
          state_next = mhpq_pkg::S_DONE;
        end
      end
      mhpq_pkg::S_DEL_HOLD: begin
        result_removed_next = rd_a;
        state_next = mhpq_pkg::S_DEL_RD;
      end
      mhpq_pkg::S_DEL_RD: begin
        if (hole == '0) begin
          cnt_next = cnt - CNT_W'(1);
          state_next = (cnt == CNT_W'(1)) ? mhpq_pkg::S_DONE : mhpq_pkg::S_LAST_RD;
        end else begin
          rd_addr_a = parent;
          state_next = mhpq_pkg::S_DEL_WR;
        end
      end
      mhpq_pkg::S_DEL_WR: begin
        wr_en = 1'b1;
        wr_data = rd_a;
        hole_next = parent;
        state_next = mhpq_pkg::S_DEL_RD;
      end
      mhpq_pkg::S_LAST_RD: begin
        rd_addr_a = cnt[IDX_W-1:0];
        state_next = mhpq_pkg::S_LAST_WAIT;
      end
      mhpq_pkg::S_LAST_WAIT: begin
        moving_next = rd_a;
        hole_next = '0;
        state_next = mhpq_pkg::S_DN_RD;
      end
      mhpq_pkg::S_DN_RD: begin
        if (lc_w >= cnt_w) begin
          wr_en = 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          rd_addr_a = lc_w[IDX_W-1:0];
          state_next = mhpq_pkg::S_DN_CMP;
        end
      end
      mhpq_pkg::S_DN_CMP: begin
        wr_en = 1'b1;
        if (rc_gt) begin
          wr_data = rd_b;
          hole_next = rc_w[IDX_W-1:0];
          state_next = mhpq_pkg::S_DN_RD;
        end else if (lc_gt) begin
          wr_data = rd_a;
          hole_next = lc_w[IDX_W-1:0];
          state_next = mhpq_pkg::S_DN_RD;
        end else begin
          state_next = mhpq_pkg::S_DONE;
        end
      end
      mhpq_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  // count grows by one for an accepted insert that fits
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == mhpq_pkg::CMD_INSERT && cnt != CNT_W'(CAPACITY))
    |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not grow the count");

  // every store write lands inside the live heap
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CNT_W'(wr_addr) < cnt)
    else $error("heap write beyond count");

  // a result word appears only after a finished command
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mhpq_pkg::S_DONE))
    else $error("result word without finished command");

endmodule

FILE: bench/max_heap_priority_queue_top_tb.sv
`timescale 1ns / 100ps

module max_heap_priority_queue_top_tb;

  localparam int CAPACITY = 64;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_BLOCKS = 20;
  localparam int BLOCK_WORDS = 100;
  localparam int HOLD_AT = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    mhpq_pkg::cmd_t op;
    logic signed [31:0] key;
    logic [5:0] pos;
    int unsigned gap;
  } heap_word_t;

  typedef struct {
    mhpq_pkg::status_t st;
    logic signed [31:0] removed;
    logic signed [31:0] top;
    logic top_valid;
    logic [6:0] count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = 2'd0;
  logic signed [31:0] key = '0;
  logic [5:0] position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [31:0] removed_value;
  logic signed [31:0] top_value;
  logic top_valid;
  logic [6:0] entry_count;

  heap_word_t pending_words[$];
  heap_result_t expected_results[$];
  heap_word_t cur_word;
  logic signed [31:0] heap_keys[CAPACITY];
  int heap_cnt = 0;
  int gen_count = 0;
  int words_total = 0;
  int words_sent = 0;
  int results_seen = 0;
  int errors = 0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int idle_cycles = 0;

  max_heap_priority_queue_top #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .key(key),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .removed_value(removed_value),
    .top_value(top_value),
    .top_valid(top_valid),
    .entry_count(entry_count)
  );

  always #2 clk = ~clk;

  function automatic void swap_keys(int a, int b);
    logic signed [31:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void sift_up_from(int p);
    int up;
    while (p != 0) begin
      up = (p - 1) / 2;
      if (!(heap_keys[up] < heap_keys[p])) break;
      swap_keys(up, p);
      p = up;
    end
  endfunction

  function automatic void sift_down_from(int p);
    int best;
    int lc;
    int rc;
    forever begin
      best = p;
      lc = p * 2 + 1;
      rc = p * 2 + 2;
      if (lc < heap_cnt && heap_keys[lc] > heap_keys[best]) best = lc;
      if (rc < heap_cnt && heap_keys[rc] > heap_keys[best]) best = rc;
      if (best == p) break;
      swap_keys(p, best);
      p = best;
    end
  endfunction

  function automatic logic signed [31:0] pop_root();
    logic signed [31:0] root;
    root = heap_keys[0];
    heap_cnt--;
    if (heap_cnt > 0) begin
      heap_keys[0] = heap_keys[heap_cnt];
      sift_down_from(0);
    end
    return root;
  endfunction

  function automatic heap_result_t apply_cmd(heap_word_t w);
    heap_result_t r;
    int p;
    r.st = mhpq_pkg::STAT_OK;
    r.removed = '0;
    case (w.op)
      mhpq_pkg::CMD_INSERT: begin
        if (heap_cnt >= CAPACITY) begin
          r.st = mhpq_pkg::STAT_FULL;
        end else begin
          heap_keys[heap_cnt] = w.key;
          heap_cnt++;
          sift_up_from(heap_cnt - 1);
        end
      end
      mhpq_pkg::CMD_EXTRACT: begin
        if (heap_cnt == 0) begin
          r.st = mhpq_pkg::STAT_EMPTY;
          r.removed = mhpq_pkg::KEY_MIN;
        end else begin
          r.removed = pop_root();
        end
      end
      mhpq_pkg::CMD_SET: begin
        if (int'(w.pos) >= heap_cnt) begin
          r.st = mhpq_pkg::STAT_BAD_INDEX;
        end else begin
          heap_keys[w.pos] = w.key;
          sift_up_from(int'(w.pos));
        end
      end
      default: begin
        if (int'(w.pos) >= heap_cnt) begin
          r.st = mhpq_pkg::STAT_BAD_INDEX;
        end else begin
          p = int'(w.pos);
          r.removed = heap_keys[p];
          // lift to the root unconditionally, then take it out
          while (p != 0) begin
            swap_keys((p - 1) / 2, p);
            p = (p - 1) / 2;
          end
          void'(pop_root());
        end
      end
    endcase
    r.top_valid = heap_cnt > 0;
    r.top = heap_cnt > 0 ? heap_keys[0] : '0;
    r.count = heap_cnt[6:0];
    return r;
  endfunction

  function automatic void queue_word(mhpq_pkg::cmd_t op, logic signed [31:0] k,
                                     logic [5:0] p, int unsigned gap);
    heap_word_t w;
    w.op = op;
    w.key = k;
    w.pos = p;
    w.gap = gap;
    pending_words.push_back(w);
    words_total++;
    case (op)
      mhpq_pkg::CMD_INSERT: if (gen_count < CAPACITY) gen_count++;
      mhpq_pkg::CMD_EXTRACT: if (gen_count > 0) gen_count--;
      mhpq_pkg::CMD_DELETE: if (int'(p) < gen_count) gen_count--;
      default: ;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 7))
      0: k = KEY_MAX;
      1: k = mhpq_pkg::KEY_MIN;
      2, 3: begin
        k = $urandom_range(0, 8);
        k = k - 4;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pick_pos();
    if (gen_count > 0 && $urandom_range(0, 7) != 0) return 6'($urandom_range(0, gen_count - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        expected_results.push_back(apply_cmd(cur_word));
        words_sent++;
        tx_wait = pending_words.size() > 0 ? pending_words[0].gap : 0;
      end
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        cmd <= cur_word.op;
        key <= cur_word.key;
        position <= cur_word.pos;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    heap_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d top %0d count %0d",
                 status, top_value, entry_count);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
          end
          if (removed_value !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed, removed_value);
            errors++;
          end
          if (top_value !== want.top) begin
            $error("top_value: expected %0d, got %0d", want.top, top_value);
            errors++;
          end
          if (top_valid !== want.top_valid) begin
            $error("top_valid: expected %0d, got %0d", want.top_valid, top_valid);
            errors++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            errors++;
          end
        end
        if (results_seen == HOLD_AT) rx_wait = HOLD_CYCLES;
        else if ((results_seen / 250) % 4 == 3) rx_wait = 0;
        else rx_wait = $urandom_range(0, 19);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ins_w;
    int unsigned gap;
    logic burst;
    for (int i = 0; i < CAPACITY; i++) heap_keys[i] = '0;

    // empty heap corner cases
    queue_word(mhpq_pkg::CMD_EXTRACT, 32'sd0, 6'd0, 0);
    queue_word(mhpq_pkg::CMD_SET, 32'sd7, 6'd0, 3);
    queue_word(mhpq_pkg::CMD_DELETE, 32'sd0, 6'd63, 0);
    // extremes and ties
    queue_word(mhpq_pkg::CMD_INSERT, mhpq_pkg::KEY_MIN, 6'd0, 0);
    queue_word(mhpq_pkg::CMD_INSERT, KEY_MAX, 6'd0, 2);
    queue_word(mhpq_pkg::CMD_INSERT, 32'sd0, 6'd0, 0);
    queue_word(mhpq_pkg::CMD_INSERT, -32'sd1, 6'd0, 0);
    queue_word(mhpq_pkg::CMD_INSERT, KEY_MAX, 6'd0, 5);
    queue_word(mhpq_pkg::CMD_INSERT, 32'sd5, 6'd0, 0);
    // raise a leaf, then lower an inner slot without sift-down
    queue_word(mhpq_pkg::CMD_SET, 32'sd100, 6'd5, 0);
    queue_word(mhpq_pkg::CMD_SET, mhpq_pkg::KEY_MIN, 6'd1, 1);
    queue_word(mhpq_pkg::CMD_SET, 32'sd3, 6'd6, 0);
    queue_word(mhpq_pkg::CMD_SET, 32'sd3, 6'd63, 0);
    // delete with max keys around
    queue_word(mhpq_pkg::CMD_DELETE, 32'sd0, 6'd5, 0);
    queue_word(mhpq_pkg::CMD_DELETE, 32'sd0, 6'd0, 4);
    queue_word(mhpq_pkg::CMD_DELETE, 32'sd0, 6'd5, 0);
    queue_word(mhpq_pkg::CMD_EXTRACT, 32'sd0, 6'd0, 0);
    queue_word(mhpq_pkg::CMD_INSERT, 32'sd1, 6'd0, 0);
    queue_word(mhpq_pkg::CMD_INSERT, 32'sd1, 6'd0, 0);
    queue_word(mhpq_pkg::CMD_DELETE, 32'sd0, 6'd2, 0);
    for (int i = 0; i < 5; i++) queue_word(mhpq_pkg::CMD_EXTRACT, 32'sd0, 6'd0, 1);

    // random blocks drifting between draining and filling
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case (b % 4)
        0: ins_w = 55;
        1: ins_w = 97;
        2: ins_w = 50;
        default: ins_w = 25;
      endcase
      burst = (b % 5 == 2);
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        gap = burst ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 99) < ins_w) begin
          queue_word(mhpq_pkg::CMD_INSERT, pick_key(), 6'($urandom), gap);
        end else begin
          case ($urandom_range(0, 2))
            0: queue_word(mhpq_pkg::CMD_EXTRACT, pick_key(), 6'($urandom), gap);
            1: queue_word(mhpq_pkg::CMD_SET, pick_key(), pick_pos(), gap);
            default: queue_word(mhpq_pkg::CMD_DELETE, pick_key(), pick_pos(), gap);
          endcase
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (words_sent < words_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
